// File: rtl/clip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_pkg
// Shared widths and pipeline records for the clip edge intersection block.
// ----------------------------------------------------------------------------
package clip_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int PROD_W    = 2 * DELTA_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int REM_W     = CROSS_W + 1;
  localparam int Q_W       = FRAC_BITS;
  localparam int SCALE_W   = Q_W + DELTA_W;

  // Side codes.
  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  // Per-item values carried alongside the arithmetic.
  typedef struct packed {
    logic [1:0]                side;
    logic signed [COORD_W-1:0] ex0;
    logic signed [COORD_W-1:0] ey0;
    logic signed [COORD_W-1:0] sx0;
    logic signed [COORD_W-1:0] sy0;
    logic signed [DELTA_W-1:0] sdx;
    logic signed [DELTA_W-1:0] sdy;
  } ctx_t;

  // One slot of the quotient pipeline.
  typedef struct packed {
    logic               valid;
    logic               ok;
    ctx_t               ctx;
    logic [REM_W-1:0]   r;
    logic [CROSS_W-1:0] d;
    logic [Q_W-1:0]     q;
  } div_t;

endpackage

// File: rtl/clip_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_cross
// Deltas, cross products, and the sign and range screen of t = num / den.
// Four register stages.
// ----------------------------------------------------------------------------
module clip_cross
  import clip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] edge_start_x,
  input  logic signed [COORD_W-1:0] edge_start_y,
  input  logic signed [COORD_W-1:0] edge_end_x,
  input  logic signed [COORD_W-1:0] edge_end_y,
  input  logic signed [COORD_W-1:0] seg_start_x,
  input  logic signed [COORD_W-1:0] seg_start_y,
  input  logic signed [COORD_W-1:0] seg_end_x,
  input  logic signed [COORD_W-1:0] seg_end_y,
  input  logic [1:0]                side,
  output div_t                      out
);

  logic                      v1, v2, v3;
  ctx_t                      c1, c2, c3;
  logic signed [DELTA_W-1:0] edx, edy, ax, ay;
  logic signed [PROD_W-1:0]  p1, p2, p3, p4;
  logic signed [CROSS_W-1:0] den, num;
  logic [CROSS_W-1:0]        den_mag, num_mag;
  logic                      screen_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= v3;
    end

    c1.side <= side;
    c1.ex0  <= edge_start_x;
    c1.ey0  <= edge_start_y;
    c1.sx0  <= seg_start_x;
    c1.sy0  <= seg_start_y;
    c1.sdx  <= DELTA_W'(seg_end_x) - DELTA_W'(seg_start_x);
    c1.sdy  <= DELTA_W'(seg_end_y) - DELTA_W'(seg_start_y);
    edx     <= DELTA_W'(edge_end_x) - DELTA_W'(edge_start_x);
    edy     <= DELTA_W'(edge_end_y) - DELTA_W'(edge_start_y);
    ax      <= DELTA_W'(edge_start_x) - DELTA_W'(seg_start_x);
    ay      <= DELTA_W'(edge_start_y) - DELTA_W'(seg_start_y);

    c2 <= c1;
    p1 <= c1.sdx * edy;
    p2 <= c1.sdy * edx;
    p3 <= ax * edy;
    p4 <= ay * edx;

    c3  <= c2;
    den <= CROSS_W'(p1) - CROSS_W'(p2);
    num <= CROSS_W'(p3) - CROSS_W'(p4);

    out.ctx <= c3;
    out.ok  <= screen_ok;
    out.r   <= REM_W'(num_mag);
    out.d   <= den_mag;
    out.q   <= '0;
  end

  always_comb begin
    den_mag = den[CROSS_W-1] ? CROSS_W'(-den) : CROSS_W'(den);
    num_mag = num[CROSS_W-1] ? CROSS_W'(-num) : CROSS_W'(num);
    // A hit needs den and num nonzero, of one sign, and |num| below |den|.
    screen_ok = (den != '0) && (num != '0) && (den[CROSS_W-1] == num[CROSS_W-1]) &&
                (num_mag < den_mag);
  end

endmodule

// File: rtl/clip_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_div_step
// One registered restoring-division step, one quotient bit.
// ----------------------------------------------------------------------------
module clip_div_step
  import clip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  div_t in,
  output div_t out
);

  logic [REM_W-1:0] r2;
  logic             take;

  always_comb begin
    r2   = {in.r[REM_W-2:0], 1'b0};
    take = (r2 >= REM_W'(in.d));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.ok  <= in.ok;
    out.ctx <= in.ctx;
    out.d   <= in.d;
    out.r   <= take ? (r2 - REM_W'(in.d)) : r2;
    out.q   <= {in.q[Q_W-2:0], take};
  end

endmodule

// File: rtl/clip_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_scale
// Scales the segment delta by t and forms the intersection point.
// Two register stages.
// ----------------------------------------------------------------------------
module clip_scale
  import clip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  div_t                      in,
  output logic                      done,
  output logic                      hit,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y
);

  logic                      v1;
  logic                      ok1;
  logic                      neg1;
  ctx_t                      c1;
  logic [SCALE_W-1:0]        prod;
  logic signed [DELTA_W-1:0] dsel;
  logic [DELTA_W-1:0]        dmag;
  logic [COORD_W-1:0]        part, sum, base;
  logic                      horiz0, horiz1;

  always_comb begin
    horiz0 = (in.ctx.side == SIDE_TOP) || (in.ctx.side == SIDE_BOTTOM);
    dsel   = horiz0 ? in.ctx.sdx : in.ctx.sdy;
    dmag   = dsel[DELTA_W-1] ? DELTA_W'(-dsel) : DELTA_W'(dsel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in.valid;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    c1   <= in.ctx;
    ok1  <= in.ok && (in.q != '0);
    neg1 <= dsel[DELTA_W-1];
    prod <= SCALE_W'(in.q) * SCALE_W'(dmag);
  end

  always_comb begin
    horiz1 = (c1.side == SIDE_TOP) || (c1.side == SIDE_BOTTOM);
    base   = horiz1 ? c1.sx0 : c1.sy0;
    part   = prod[FRAC_BITS +: COORD_W];
    if (neg1) begin
      part = -part;
    end
    sum = base + part;
  end

  always_ff @(posedge clk) begin
    hit <= ok1;
    if (!ok1) begin
      point_x <= '0;
      point_y <= '0;
    end else if (horiz1) begin
      point_x <= sum;
      point_y <= c1.ey0;
    end else begin
      point_x <= c1.ex0;
      point_y <= sum;
    end
  end

endmodule

// File: rtl/clip_edge_segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_edge_segment_intersection
// Intersection of a polygon segment with a clip edge, Q16.16, fully pipelined.
// Four cross-product stages, one division stage per quotient bit and two scaling
// stages. Throughput: one transaction per cycle; busy stays low.
// Reset clears all valid bits, dropping any item in flight; there is no stall input.
// ----------------------------------------------------------------------------
module clip_edge_segment_intersection
  import clip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] edge_start_x,
  input  logic signed [COORD_W-1:0] edge_start_y,
  input  logic signed [COORD_W-1:0] edge_end_x,
  input  logic signed [COORD_W-1:0] edge_end_y,
  input  logic signed [COORD_W-1:0] seg_start_x,
  input  logic signed [COORD_W-1:0] seg_start_y,
  input  logic signed [COORD_W-1:0] seg_end_x,
  input  logic signed [COORD_W-1:0] seg_end_y,
  input  logic [1:0]                side,
  output logic                      done,
  output logic                      hit,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y
);

  div_t stage [0:FRAC_BITS];

  assign busy = 1'b0;

  clip_cross u_cross (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .edge_start_x (edge_start_x),
    .edge_start_y (edge_start_y),
    .edge_end_x   (edge_end_x),
    .edge_end_y   (edge_end_y),
    .seg_start_x  (seg_start_x),
    .seg_start_y  (seg_start_y),
    .seg_end_x    (seg_end_x),
    .seg_end_y    (seg_end_y),
    .side         (side),
    .out          (stage[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    clip_div_step u_step (
      .clk (clk),
      .rst (rst),
      .in  (stage[i]),
      .out (stage[i+1])
    );
  end

  clip_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .in      (stage[FRAC_BITS]),
    .done    (done),
    .hit     (hit),
    .point_x (point_x),
    .point_y (point_y)
  );

endmodule
